[rtl/pevq_pkg.sv]
`default_nettype none
package pevq_pkg;

  // default ring depth, entry width, reset values and screen size limit
  localparam int unsigned QueueDepthDef = 256;
  localparam int unsigned EntryW        = 56;
  localparam logic [12:0] WidthRst      = 13'd640;
  localparam logic [12:0] HeightRst     = 13'd480;
  localparam logic [12:0] ScreenMax     = 13'd4096;

  // item kinds
  typedef enum logic {
    KIND_POST = 1'b0,
    KIND_POP  = 1'b1
  } kind_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_RELATIVE_MODE = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [15:0] wheel_delta;
    logic [7:0]         button_bits;
  } in_item_t;

  typedef struct packed {
    logic               event_valid;
    logic signed [15:0] out_dx;
    logic signed [15:0] out_dy;
    logic signed [15:0] out_wheel;
    logic [7:0]         out_buttons;
    logic               dropped;
    logic [11:0]        col_pos;
    logic [11:0]        row_pos;
    logic               has_moved;
    logic [7:0]         pending;
  } out_item_t;

  // everything of a result except the event read back from the ring
  typedef struct packed {
    logic        event_valid;
    logic        dropped;
    logic [11:0] col_pos;
    logic [11:0] row_pos;
    logic        has_moved;
    logic [7:0]  pending;
  } res_meta_t;

endpackage
`default_nettype wire

[rtl/pevq_store.sv]
`default_nettype none
module pevq_store import pevq_pkg::*; #(
  parameter int unsigned DEPTH  = QueueDepthDef,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [EntryW-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [EntryW-1:0] rdata_o
);

  logic [EntryW-1:0] mem [DEPTH];
  logic [EntryW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds its data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/pevq_clamp.sv]
`default_nettype none
module pevq_clamp (
  input  wire logic        [11:0] pos_i,
  input  wire logic signed [15:0] delta_i,
  input  wire logic        [12:0] size_i,
  output logic             [11:0] pos_o
);

  logic signed [17:0] sum;
  logic signed [17:0] size_s;
  logic        [12:0] last;

  assign sum    = $signed({6'b0, pos_i}) + $signed({{2{delta_i[15]}}, delta_i});
  assign size_s = $signed({5'b0, size_i});
  assign last   = size_i - 13'd1;

  // move and clamp to the range zero to size minus one
  always_comb begin
    if (sum < 18'sd0) begin
      pos_o = 12'd0;
    end else if (sum >= size_s) begin
      pos_o = last[11:0];
    end else begin
      pos_o = sum[11:0];
    end
  end

endmodule
`default_nettype wire

[rtl/pointer_event_queue_with_cursor.sv]
`default_nettype none
// Pointer event queue with a clamped cursor. Each transaction on the input
// channel is a post (queue a motion event and move the cursor) or a pop
// (dequeue the oldest event); every item yields exactly one result. The block
// takes one item per clock cycle and its result is valid in the cycle after
// acceptance, the latency being set by the registered read port of the event
// ring memory. The input stalls only while a finished result is held by a
// stalled output. Events live in a QUEUE_DEPTH-entry RAM that holds at most
// QUEUE_DEPTH-1 events; a post into a full ring is dropped and flagged. No
// clearing pass follows reset: the ring is tracked by pointers and a count.
// Configuration (screen width, screen height, relative mode) has its own
// valid/ready port; users write it only with no item in flight, unchecked.
module pointer_event_queue_with_cursor import pevq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [12:0] cfg_data_i
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, count_q, count_d;
  logic [11:0]     col_q, col_d, row_q, row_d;
  logic            moved_q, moved_d, rel_q, rel_d;
  logic [12:0]     width_q, width_d, height_q, height_d;
  logic            out_valid_q, out_valid_d;
  res_meta_t       meta_q, meta_d;

  logic              in_acc, cfg_acc, mem_we, mem_re;
  logic [EntryW-1:0] mem_wdata, mem_rdata;
  logic [11:0]       col_clamp, row_clamp;
  logic [12:0]       cfg_sat;
  logic [12:0]       count_ext;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  pevq_clamp u_clamp_x (
    .pos_i   (col_q),
    .delta_i (in_data_i.delta_x),
    .size_i  (width_q),
    .pos_o   (col_clamp)
  );

  pevq_clamp u_clamp_y (
    .pos_i   (row_q),
    .delta_i (in_data_i.delta_y),
    .size_i  (height_q),
    .pos_o   (row_clamp)
  );

  assign mem_wdata = {in_data_i.button_bits, in_data_i.wheel_delta,
                      in_data_i.delta_y, in_data_i.delta_x};

  pevq_store #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (PtrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (mem_rdata)
  );

  // saturated screen size from a configuration write
  assign cfg_sat = (cfg_data_i > ScreenMax) ? ScreenMax : cfg_data_i;

  // item and configuration update
  always_comb begin
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    count_d     = count_q;
    col_d       = col_q;
    row_d       = row_q;
    moved_d     = moved_q;
    rel_d       = rel_q;
    width_d     = width_q;
    height_d    = height_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    meta_d      = meta_q;
    out_valid_d = out_valid_q & out_stall_i;

    if (in_acc) begin
      meta_d.event_valid = 1'b0;
      meta_d.dropped     = 1'b0;
      if (in_data_i.kind == KIND_POST) begin
        if ((in_data_i.delta_x != 16'sd0) || (in_data_i.delta_y != 16'sd0)) begin
          moved_d = 1'b1;
        end
        if (rel_q) begin
          col_d = width_q[12:1];
          row_d = height_q[12:1];
        end else begin
          col_d = col_clamp;
          row_d = row_clamp;
        end
        if (count_q == PtrLast) begin
          meta_d.dropped = 1'b1;
        end else begin
          mem_we   = 1'b1;
          wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
          count_d  = count_q + 1'b1;
        end
      end else if (count_q != '0) begin
        mem_re             = 1'b1;
        meta_d.event_valid = 1'b1;
        rd_ptr_d           = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
        count_d            = count_q - 1'b1;
      end
      out_valid_d = 1'b1;
    end

    // configuration writes; the user issues them only while idle, unchecked
    if (cfg_acc) begin
      case (cfg_index_i)
        CFG_SCREEN_WIDTH: begin
          if (cfg_data_i != 13'd0) begin
            width_d = cfg_sat;
            col_d   = cfg_sat[12:1];
            row_d   = height_q[12:1];
          end
        end
        CFG_SCREEN_HEIGHT: begin
          if (cfg_data_i != 13'd0) begin
            height_d = cfg_sat;
            col_d    = width_q[12:1];
            row_d    = cfg_sat[12:1];
          end
        end
        CFG_RELATIVE_MODE: begin
          rel_d    = cfg_data_i[0];
          col_d    = width_q[12:1];
          row_d    = height_q[12:1];
          rd_ptr_d = wr_ptr_q;
          count_d  = '0;
        end
        default: begin
        end
      endcase
    end

    count_ext = 13'(count_d);
    if (in_acc) begin
      meta_d.col_pos   = col_d;
      meta_d.row_pos   = row_d;
      meta_d.has_moved = moved_d;
      meta_d.pending   = (count_ext > 13'd255) ? 8'd255 : count_ext[7:0];
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      col_q       <= WidthRst[12:1];
      row_q       <= HeightRst[12:1];
      moved_q     <= 1'b0;
      rel_q       <= 1'b0;
      width_q     <= WidthRst;
      height_q    <= HeightRst;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      count_q     <= count_d;
      col_q       <= col_d;
      row_q       <= row_d;
      moved_q     <= moved_d;
      rel_q       <= rel_d;
      width_q     <= width_d;
      height_q    <= height_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    meta_q <= meta_d;
  end

  // result assembly, event fields straight from the ring read port
  always_comb begin
    out_data_o.event_valid = meta_q.event_valid;
    out_data_o.out_dx      = meta_q.event_valid ? $signed(mem_rdata[15:0])  : 16'sd0;
    out_data_o.out_dy      = meta_q.event_valid ? $signed(mem_rdata[31:16]) : 16'sd0;
    out_data_o.out_wheel   = meta_q.event_valid ? $signed(mem_rdata[47:32]) : 16'sd0;
    out_data_o.out_buttons = meta_q.event_valid ? mem_rdata[55:48] : 8'd0;
    out_data_o.dropped     = meta_q.dropped;
    out_data_o.col_pos     = meta_q.col_pos;
    out_data_o.row_pos     = meta_q.row_pos;
    out_data_o.has_moved   = meta_q.has_moved;
    out_data_o.pending     = meta_q.pending;
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

[tb/tb_top.sv]
module tb_top;
  import pevq_pkg::*;

  localparam int unsigned RING_DEPTH  = QueueDepthDef;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned MAX_PRINTS  = 200;

  // stored copy of one queued event
  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] wheel;
    logic [7:0]         buttons;
  } ring_entry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [12:0] cfg_data_i;

  // knobs for gaps, receiver stalls and the long hold-off
  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;
  logic        hold_on    = 1'b0;
  int unsigned cycle_cnt  = 0;

  // event queue and cursor as the block should hold them
  ring_entry_t ring_mem [RING_DEPTH];
  int unsigned wr_idx;
  int unsigned rd_idx;
  logic [11:0] cur_col;
  logic [11:0] cur_row;
  logic        moved;
  logic [12:0] scr_w;
  logic [12:0] scr_h;
  logic        rel_mode;

  out_item_t   expected_reports [$];

  int unsigned err_cnt    = 0;
  int unsigned n_checked  = 0;
  int unsigned n_posts    = 0;
  int unsigned n_drops    = 0;
  int unsigned n_pops     = 0;
  int unsigned n_dequeued = 0;
  int unsigned n_writes   = 0;

  pointer_event_queue_with_cursor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("pointer_event_queue_with_cursor verification failed");
      $finish;
    end
  end

  // receiver stalls, forced high during the long hold-off
  always @(posedge clk_i) begin
    if (hold_on) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic note_failure(string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  task automatic cmp_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      note_failure($sformatf("result %0d %s: got %0h, expected %0h",
                             n_checked, name, got, want));
    end
  endtask

  // compare every accepted result transaction with the oldest expectation
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_reports.size() == 0) begin
        note_failure("result arrived with nothing expected");
      end else begin
        want = expected_reports.pop_front();
        cmp_field("event_valid", out_data_o.event_valid, want.event_valid);
        cmp_field("out_dx", out_data_o.out_dx, want.out_dx);
        cmp_field("out_dy", out_data_o.out_dy, want.out_dy);
        cmp_field("out_wheel", out_data_o.out_wheel, want.out_wheel);
        cmp_field("out_buttons", out_data_o.out_buttons, want.out_buttons);
        cmp_field("dropped", out_data_o.dropped, want.dropped);
        cmp_field("col_pos", out_data_o.col_pos, want.col_pos);
        cmp_field("row_pos", out_data_o.row_pos, want.row_pos);
        cmp_field("has_moved", out_data_o.has_moved, want.has_moved);
        cmp_field("pending", out_data_o.pending, want.pending);
        n_checked++;
      end
    end
  end

  function automatic int unsigned ring_fill();
    return (wr_idx + RING_DEPTH - rd_idx) % RING_DEPTH;
  endfunction

  function automatic void recenter();
    cur_col = 12'(scr_w >> 1);
    cur_row = 12'(scr_h >> 1);
  endfunction

  function automatic logic [11:0] clamp_axis(logic [11:0] pos, logic signed [15:0] step,
                                             logic [12:0] span);
    int n;
    n = int'(pos) + int'(step);
    if (n < 0) n = 0;
    if (n >= int'(span)) n = int'(span) - 1;
    return 12'(n);
  endfunction

  function automatic void reset_tracker();
    wr_idx   = 0;
    rd_idx   = 0;
    scr_w    = WidthRst;
    scr_h    = HeightRst;
    rel_mode = 1'b0;
    moved    = 1'b0;
    recenter();
  endfunction

  // register write side effects: zero sizes ignored, big ones saturate
  function automatic void apply_reg(cfg_idx_e idx, logic [12:0] val);
    logic [12:0] sat;
    sat = (val > ScreenMax) ? ScreenMax : val;
    case (idx)
      CFG_SCREEN_WIDTH: begin
        if (val != 0) begin
          scr_w = sat;
          recenter();
        end
      end
      CFG_SCREEN_HEIGHT: begin
        if (val != 0) begin
          scr_h = sat;
          recenter();
        end
      end
      CFG_RELATIVE_MODE: begin
        rel_mode = val[0];
        recenter();
        rd_idx = wr_idx;
      end
      default: ;
    endcase
  endfunction

  // work out the report for one post or pop and queue it
  function automatic void predict_report(in_item_t it);
    out_item_t   r;
    ring_entry_t e;
    int unsigned fill;
    r = '0;
    fill = ring_fill();
    if (it.kind == KIND_POST) begin
      n_posts++;
      if (it.delta_x != 0 || it.delta_y != 0) moved = 1'b1;
      if (!rel_mode) begin
        cur_col = clamp_axis(cur_col, it.delta_x, scr_w);
        cur_row = clamp_axis(cur_row, it.delta_y, scr_h);
      end else begin
        recenter();
      end
      if (fill == RING_DEPTH - 1) begin
        r.dropped = 1'b1;
        n_drops++;
      end else begin
        e.dx      = it.delta_x;
        e.dy      = it.delta_y;
        e.wheel   = it.wheel_delta;
        e.buttons = it.button_bits;
        ring_mem[wr_idx] = e;
        wr_idx = (wr_idx + 1) % RING_DEPTH;
      end
    end else begin
      n_pops++;
      if (fill != 0) begin
        e = ring_mem[rd_idx];
        rd_idx = (rd_idx + 1) % RING_DEPTH;
        r.event_valid = 1'b1;
        r.out_dx      = e.dx;
        r.out_dy      = e.dy;
        r.out_wheel   = e.wheel;
        r.out_buttons = e.buttons;
        n_dequeued++;
      end
    end
    fill = ring_fill();
    r.col_pos   = cur_col;
    r.row_pos   = cur_row;
    r.has_moved = moved;
    r.pending   = (fill > 255) ? 8'd255 : 8'(fill);
    expected_reports.push_back(r);
  endfunction

  function automatic in_item_t make_post(logic signed [15:0] dx, logic signed [15:0] dy,
                                         logic signed [15:0] wh, logic [7:0] bt);
    in_item_t it;
    it.kind        = KIND_POST;
    it.delta_x     = dx;
    it.delta_y     = dy;
    it.wheel_delta = wh;
    it.button_bits = bt;
    return it;
  endfunction

  // pops carry random junk in the unused fields
  function automatic in_item_t make_pop();
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.kind = KIND_POP;
    return it;
  endfunction

  function automatic logic [15:0] rand_motion();
    case ($urandom_range(9))
      0:             return '0;
      1, 2, 3, 4, 5: return 16'(int'($urandom_range(40)) - 20);
      6:             return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default:       return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_item(int unsigned pop_pct);
    if ($urandom_range(99) < pop_pct) return make_pop();
    return make_post(rand_motion(), rand_motion(), rand_motion(), 8'($urandom));
  endfunction

  function automatic logic [12:0] pick_screen_size();
    case ($urandom_range(7))
      0:       return 13'd1;
      1:       return 13'd2;
      2:       return 13'($urandom_range(3, 64));
      3:       return 13'($urandom_range(65, 4096));
      4:       return ScreenMax;
      5:       return 13'($urandom_range(4097, 8191));
      6:       return 13'd0;
      default: return WidthRst;
    endcase
  endfunction

  // offer one item, with an optional gap first, and wait for its transaction
  task automatic send_item(in_item_t it);
    cfg_valid_i <= 1'b0;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_report(it);
  endtask

  // only called while the block is idle
  task automatic write_reg(cfg_idx_e idx, logic [12:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    apply_reg(idx, val);
    n_writes++;
  endtask

  task automatic wait_idle();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic random_setting();
    wait_idle();
    write_reg(CFG_SCREEN_WIDTH, pick_screen_size());
    write_reg(CFG_SCREEN_HEIGHT, pick_screen_size());
    write_reg(CFG_RELATIVE_MODE, {12'($urandom), 1'($urandom_range(9) < 3)});
  endtask

  // pops on empty, clamping at both edges, wheel-only motion
  task automatic test_directed_items();
    send_item(make_pop());
    send_item(make_post(16'sd0, 16'sd0, 16'sd12, 8'h00));
    send_item(make_pop());
    send_item(make_post(16'sh7fff, 16'sh7fff, 16'sh7fff, 8'hff));
    send_item(make_post(16'sh8000, 16'sh8000, 16'sh8000, 8'h80));
    send_item(make_post(16'sd1, -16'sd1, 16'sd0, 8'h01));
    send_item(make_post(-16'sd1, 16'sd1, -16'sd1, 8'h7f));
    send_item(make_post(16'sd0, 16'sh7fff, 16'sd0, 8'h55));
    repeat (6) send_item(make_pop());
  endtask

  // ignored zero sizes, saturation, 1x1 screen, relative mode flush
  task automatic test_register_extremes();
    wait_idle();
    write_reg(CFG_SCREEN_WIDTH, 13'd0);
    write_reg(CFG_SCREEN_HEIGHT, 13'd0);
    write_reg(CFG_UNUSED, 13'h1fff);
    send_item(make_post(16'sd100, 16'sd100, 16'sd0, 8'h0f));
    wait_idle();
    write_reg(CFG_SCREEN_WIDTH, 13'h1fff);
    write_reg(CFG_SCREEN_HEIGHT, 13'd4097);
    send_item(make_post(16'sh7fff, 16'sh7fff, 16'sd3, 8'hf0));
    send_item(make_post(16'sh8000, 16'sd5, 16'sd0, 8'h00));
    wait_idle();
    write_reg(CFG_SCREEN_WIDTH, 13'd1);
    write_reg(CFG_SCREEN_HEIGHT, 13'd1);
    send_item(make_post(16'sd5, 16'sd5, 16'sd0, 8'h11));
    send_item(make_post(-16'sd5, -16'sd5, 16'sd0, 8'h22));
    wait_idle();
    write_reg(CFG_RELATIVE_MODE, 13'd1);
    send_item(make_pop());
    send_item(make_post(16'sd100, -16'sd100, 16'sd7, 8'h33));
    wait_idle();
    write_reg(CFG_SCREEN_WIDTH, 13'd1000);
    send_item(make_post(16'sd9, 16'sd9, 16'sd0, 8'h44));
    send_item(make_pop());
    send_item(make_pop());
    send_item(make_pop());
    wait_idle();
    write_reg(CFG_RELATIVE_MODE, 13'h1ffe);
    write_reg(CFG_SCREEN_WIDTH, WidthRst);
    write_reg(CFG_SCREEN_HEIGHT, HeightRst);
  endtask

  // fill the ring until posts drop, then drain it past empty
  task automatic test_ring_overflow();
    int unsigned drops_at_start;
    drops_at_start = n_drops;
    random_setting();
    gap_pct   = 18;
    stall_pct <= 18;
    while (n_drops < drops_at_start + 4) begin
      send_item(rand_item(0));
    end
    while (ring_fill() != 0) send_item(make_pop());
    repeat (3) send_item(make_pop());
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    wait_idle();
    gap_pct   = 0;
    stall_pct <= 0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_on <= 1'b0;
      end
    join_none
    repeat (60) send_item(rand_item(35));
  endtask

  // random traffic under one idling pattern, settings changed now and then
  task automatic test_random_traffic(int unsigned n_items, int unsigned gaps,
                                     int unsigned stalls);
    int unsigned pop_pct;
    pop_pct = 50;
    random_setting();
    gap_pct   = gaps;
    stall_pct <= stalls;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 40 == 0) pop_pct = $urandom_range(20, 65);
      if (i % 90 == 89) random_setting();
      send_item(rand_item(pop_pct));
    end
  endtask

  initial begin
    int unsigned guard;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_SCREEN_WIDTH;
    cfg_data_i  = '0;
    reset_tracker();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_items();
    test_register_extremes();
    test_ring_overflow();
    test_backpressure();
    test_random_traffic(270, 0, 0);
    test_random_traffic(270, 54, 0);
    test_random_traffic(270, 0, 54);
    test_random_traffic(270, 18, 18);

    // drain, then wait out anything stray
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    guard = 0;
    while (expected_reports.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE) @(posedge clk_i);
    if (expected_reports.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_reports.size()));
    end

    $display("covered %0d posts (%0d lost to a full ring) and %0d pops (%0d returned an event)",
             n_posts, n_drops, n_pops, n_dequeued);
    $display("%0d register writes, %0d results compared, %0d mismatches",
             n_writes, n_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("pointer_event_queue_with_cursor verification clean");
    end else begin
      $display("pointer_event_queue_with_cursor verification failed");
    end
    $finish;
  end

endmodule
